/* rtl/pgf_pkg.sv */
// ----------------------------------------------------------------------------
// pgf_pkg: shared types and constants for the pairwise gravity force block
// Field widths, item structs, register indexes and pipeline unit widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pgf_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int GRAV_W  = 32;
  localparam int DSQ_W   = 64;
  localparam int FORCE_W = 32;

  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int SUMSQ_W   = SQ_W;
  localparam int GM_W      = GRAV_W + MASS_W;
  localparam int PROD_W    = GM_W + MASS_W;
  localparam int MAG_W     = 64;
  localparam int UNIT_BITS = 30;
  localparam int UNIT_W    = UNIT_BITS + 1;

  localparam int ROOT_W     = 34;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQRT_REM_W = ROOT_W + 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DSQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DSQ = 2'd2;

  localparam logic [GRAV_W-1:0] GRAV_RESET    = GRAV_W'(1) << FRAC_BITS;
  localparam logic [DSQ_W-1:0]  MIN_DSQ_RESET = DSQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [DSQ_W-1:0]  MAX_DSQ_RESET = DSQ_W'(100) << (2 * FRAC_BITS);

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic [MASS_W-1:0]       a_mass;
    logic [MASS_W-1:0]       b_mass;
  } pair_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      saturated;
  } result_t;

endpackage

`default_nettype wire

/* rtl/pgf_div.sv */
// ----------------------------------------------------------------------------
// pgf_div: pipelined restoring divider
// One quotient bit per stage. The remainder start value must be below the
// divisor; quotient bits shift in behind the dividend bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_div #(
  parameter int DW = 64,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] dvs_q [QW-1];
  logic [QW-1:0] lo_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] l_in;
    logic [DW:0]   cur;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign r_in = rem_init;
      assign d_in = dvs;
      assign l_in = dvd;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = dvs_q[k-1];
      assign l_in = lo_q[k-1];
    end

    assign cur  = {r_in, l_in[QW-1]};
    assign diff = cur - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        lo_q[k] <= {l_in[QW-2:0], ~diff[DW]};
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= diff[DW] ? cur[DW-1:0] : diff[DW-1:0];
          dvs_q[k] <= d_in;
        end
      end
    end
  end

  assign quo = lo_q[QW-1];

endmodule

`default_nettype wire

/* rtl/pgf_sqrt.sv */
// ----------------------------------------------------------------------------
// pgf_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per stage; gives floor(sqrt(rad)).
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_sqrt import pgf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [SQRT_REM_W-1:0] rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]      rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0]     root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [SQRT_REM_W-1:0] r_in;
    logic [RAD_W-1:0]      a_in;
    logic [ROOT_W-1:0]     q_in;
    logic [SQRT_REM_W-1:0] cur;
    logic [SQRT_REM_W-1:0] trial;
    logic [SQRT_REM_W:0]   diff;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign a_in = rad;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign a_in = rad_q[k-1];
      assign q_in = root_q[k-1];
    end

    assign cur   = {r_in[SQRT_REM_W-3:0], a_in[RAD_W-1:RAD_W-2]};
    assign trial = {(SQRT_REM_W-2)'(q_in), 2'b01};
    assign diff  = {1'b0, cur} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {q_in[ROOT_W-2:0], ~diff[SQRT_REM_W]};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= diff[SQRT_REM_W] ? cur : diff[SQRT_REM_W-1:0];
          rad_q[k] <= {a_in[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/pairwise_gravity_force.sv */
// ----------------------------------------------------------------------------
// pairwise_gravity_force: 2D Newtonian force on body A from body B
// Takes one pair of bodies per cycle and returns the saturated force on A.
// The longest path is the 64-stage divider for G*mA*mB / clamped squared
// distance, which runs beside the 34-stage square root and the 31-stage unit
// vector dividers that follow it. A stalled result holds the whole pipeline;
// with no stall one item enters and one leaves every cycle. Configuration
// writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_gravity_force import pgf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  pair_t                pair_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output result_t              res_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DSQ_W-1:0]     cfg_data
);

  localparam int ROOT_AT = 3 + ROOT_W;
  localparam int U_AT    = ROOT_AT + UNIT_W;
  localparam int Q_AT    = 5 + MAG_W;
  localparam int MAG_AT  = Q_AT + 1;
  localparam int U_DLY   = MAG_AT - U_AT;
  localparam int LAT     = MAG_AT + 3;
  localparam int SIDE_W  = 2 * DIFF_W + 2;

  function automatic logic [FORCE_W:0] clip(input logic neg, input logic [MAG_W-1:0] m);
    logic [FORCE_W:0] r;
    if (!neg) begin
      if (m > MAG_W'(FORCE_MAX)) r = {1'b1, FORCE_MAX};
      else r = {1'b0, m[FORCE_W-1:0]};
    end else begin
      if (m > {{(MAG_W-FORCE_W){1'b0}}, FORCE_MIN}) r = {1'b1, FORCE_MIN};
      else r = {1'b0, ~m[FORCE_W-1:0] + FORCE_W'(1)};
    end
    return r;
  endfunction

  logic [GRAV_W-1:0] grav;
  logic [DSQ_W-1:0]  min_dsq;
  logic [DSQ_W-1:0]  max_dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav    <= GRAV_RESET;
      min_dsq <= MIN_DSQ_RESET;
      max_dsq <= MAX_DSQ_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAV:    grav    <= cfg_data[GRAV_W-1:0];
        REG_MIN_DSQ: min_dsq <= cfg_data;
        REG_MAX_DSQ: max_dsq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic           en;
  logic [LAT-1:0] vld;

  assign en         = !(res_valid && res_stall);
  assign pair_stall = !en;
  assign res_valid  = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pair_valid};
    end
  end

  // stage 1: differences, G*mA
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        ax1, ay1;
  logic                     sx1, sy1;
  logic [GM_W-1:0]          gma1;
  logic [MASS_W-1:0]        mb1;

  assign dx = DIFF_W'(pair_data.b_pos_x) - DIFF_W'(pair_data.a_pos_x);
  assign dy = DIFF_W'(pair_data.b_pos_y) - DIFF_W'(pair_data.a_pos_y);

  always_ff @(posedge clk) begin
    if (en) begin
      ax1  <= dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
      ay1  <= dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
      sx1  <= dx[DIFF_W-1];
      sy1  <= dy[DIFF_W-1];
      gma1 <= GM_W'(grav) * GM_W'(pair_data.a_mass);
      mb1  <= pair_data.b_mass;
    end
  end

  // stage 2: squares and partial products of the mass term
  logic [SQ_W-1:0]   sxx2, syy2;
  logic [GM_W-1:0]   ppl2, pph2;
  logic [DIFF_W-1:0] ax2, ay2;
  logic              sx2, sy2;

  always_ff @(posedge clk) begin
    if (en) begin
      sxx2 <= SQ_W'(ax1) * SQ_W'(ax1);
      syy2 <= SQ_W'(ay1) * SQ_W'(ay1);
      ppl2 <= GM_W'(gma1[GM_W/2-1:0]) * GM_W'(mb1);
      pph2 <= GM_W'(gma1[GM_W-1:GM_W/2]) * GM_W'(mb1);
      ax2  <= ax1;
      ay2  <= ay1;
      sx2  <= sx1;
      sy2  <= sy1;
    end
  end

  // stage 3: squared distance and mass product
  logic [SUMSQ_W-1:0] s3;
  logic [PROD_W-1:0]  p3;
  logic [DIFF_W-1:0]  ax3, ay3;
  logic               sx3, sy3;

  always_ff @(posedge clk) begin
    if (en) begin
      s3  <= sxx2 + syy2;
      p3  <= {pph2, {(GM_W/2){1'b0}}} + PROD_W'(ppl2);
      ax3 <= ax2;
      ay3 <= ay2;
      sx3 <= sx2;
      sy3 <= sy2;
    end
  end

  // stage 4: clamp
  logic [DSQ_W-1:0]  v3;
  logic [DSQ_W-1:0]  c4;
  logic [PROD_W-1:0] p4;

  assign v3 = (|s3[SUMSQ_W-1:DSQ_W]) ? '1 : s3[DSQ_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (v3 < min_dsq) c4 <= min_dsq;
      else if (v3 > max_dsq)     c4 <= max_dsq;
      else                       c4 <= v3;
      p4 <= p3;
    end
  end

  // stage 5: overflow and zero checks ahead of the divider
  logic [DSQ_W-1:0]  c5;
  logic [PROD_W-1:0] p5;
  logic              ovf5, cz5, pz5;

  always_ff @(posedge clk) begin
    if (en) begin
      c5   <= c4;
      p5   <= p4;
      ovf5 <= DSQ_W'(p4[PROD_W-1:MAG_W]) >= c4;
      cz5  <= c4 == '0;
      pz5  <= p4 == '0;
    end
  end

  logic [MAG_W-1:0] q;
  logic [2:0]       fl_dly [MAG_W];

  pgf_div #(.DW(DSQ_W), .QW(MAG_W)) u_div_mag (
    .clk      (clk),
    .en       (en),
    .rem_init (DSQ_W'(p5[PROD_W-1:MAG_W])),
    .dvd      (p5[MAG_W-1:0]),
    .dvs      (c5),
    .quo      (q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fl_dly[0] <= {ovf5, cz5, pz5};
      for (int i = 1; i < MAG_W; i++) fl_dly[i] <= fl_dly[i-1];
    end
  end

  // magnitude with saturation
  localparam logic [MAG_W-1:0] MAG_SAT = {1'b1, {(MAG_W-1){1'b0}}};
  logic [MAG_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (fl_dly[MAG_W-1][1])               mag <= fl_dly[MAG_W-1][0] ? '0 : MAG_SAT;
      else if (fl_dly[MAG_W-1][2] || q > MAG_SAT)    mag <= MAG_SAT;
      else                                           mag <= q;
    end
  end

  // length and unit vector
  logic [ROOT_W-1:0] len;
  logic [SIDE_W-1:0] side_dly [ROOT_W];
  logic [DIFF_W-1:0] axr, ayr;
  logic              sxr, syr;

  pgf_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'(s3)),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= {ax3, ay3, sx3, sy3};
      for (int i = 1; i < ROOT_W; i++) side_dly[i] <= side_dly[i-1];
    end
  end

  assign {axr, ayr, sxr, syr} = side_dly[ROOT_W-1];

  logic [UNIT_W-1:0] ux, uy;

  pgf_div #(.DW(ROOT_W), .QW(UNIT_W)) u_div_ux (
    .clk      (clk),
    .en       (en),
    .rem_init (ROOT_W'(axr[DIFF_W-1:1])),
    .dvd      ({axr[0], {UNIT_BITS{1'b0}}}),
    .dvs      (len),
    .quo      (ux)
  );

  pgf_div #(.DW(ROOT_W), .QW(UNIT_W)) u_div_uy (
    .clk      (clk),
    .en       (en),
    .rem_init (ROOT_W'(ayr[DIFF_W-1:1])),
    .dvd      ({ayr[0], {UNIT_BITS{1'b0}}}),
    .dvs      (len),
    .quo      (uy)
  );

  logic [2:0]            sg_dly [UNIT_W+U_DLY];
  logic [2*UNIT_W-1:0]   u_dly  [U_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      sg_dly[0] <= {len == '0, sxr, syr};
      for (int i = 1; i < UNIT_W + U_DLY; i++) sg_dly[i] <= sg_dly[i-1];
      u_dly[0] <= {ux, uy};
      for (int i = 1; i < U_DLY; i++) u_dly[i] <= u_dly[i-1];
    end
  end

  // scale by magnitude
  localparam int PP_W = MAG_W / 2 + UNIT_W;
  logic [PP_W-1:0] pxl, pxh, pyl, pyh;
  logic [2:0]      sg6;

  always_ff @(posedge clk) begin
    if (en) begin
      pxl <= PP_W'(mag[MAG_W/2-1:0]) * PP_W'(u_dly[U_DLY-1][2*UNIT_W-1:UNIT_W]);
      pxh <= PP_W'(mag[MAG_W-1:MAG_W/2]) * PP_W'(u_dly[U_DLY-1][2*UNIT_W-1:UNIT_W]);
      pyl <= PP_W'(mag[MAG_W/2-1:0]) * PP_W'(u_dly[U_DLY-1][UNIT_W-1:0]);
      pyh <= PP_W'(mag[MAG_W-1:MAG_W/2]) * PP_W'(u_dly[U_DLY-1][UNIT_W-1:0]);
      sg6 <= sg_dly[UNIT_W+U_DLY-1];
    end
  end

  localparam int FULL_W = PP_W + MAG_W / 2 + 1;
  logic [FULL_W-1:0] fx, fy;
  logic [MAG_W-1:0]  mx, my;
  logic [2:0]        sg7;

  assign fx = {1'b0, pxh, {(MAG_W/2){1'b0}}} + FULL_W'(pxl);
  assign fy = {1'b0, pyh, {(MAG_W/2){1'b0}}} + FULL_W'(pyl);

  always_ff @(posedge clk) begin
    if (en) begin
      mx  <= fx[UNIT_BITS+MAG_W-1:UNIT_BITS];
      my  <= fy[UNIT_BITS+MAG_W-1:UNIT_BITS];
      sg7 <= sg6;
    end
  end

  // output register: sign, clipping, coincident bodies
  logic [FORCE_W:0] cx, cy;

  assign cx = clip(sg7[1], mx);
  assign cy = clip(sg7[0], my);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sg7[2]) begin
        res_data <= '0;
      end else begin
        res_data.force_x   <= cx[FORCE_W-1:0];
        res_data.force_y   <= cy[FORCE_W-1:0];
        res_data.saturated <= cx[FORCE_W] | cy[FORCE_W];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pgf_checker.sv */
// ----------------------------------------------------------------------------
// pgf_checker: port-level checks for pairwise_gravity_force
// Handshake hold rules, back-pressure, saturation flag consistency and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_checker import pgf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    pair_stall,
  input logic    res_valid,
  input logic    res_stall,
  input result_t res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> pair_stall)
    else $error("input taken while output blocked");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.saturated |->
      (res_data.force_x == FORCE_MAX || res_data.force_x == FORCE_MIN ||
       res_data.force_y == FORCE_MAX || res_data.force_y == FORCE_MIN))
    else $error("saturated flag without clipped component");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind pairwise_gravity_force pgf_checker u_pgf_checker (.*);

`default_nettype wire

/* tb/sv/tb_pairwise_gravity_force.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_force: self-checking bench for the pair force pipeline
// Drives body pairs with random gaps and result back-pressure, predicts the
// force on body A in wide integer arithmetic, and checks every result in order.
// The gravity constant and distance clamp bounds are swept between phases.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_force;
  import pgf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

  logic                 clk;
  logic                 rst;
  logic                 pair_valid;
  logic                 pair_stall;
  pair_t                pair_data;
  logic                 res_valid;
  logic                 res_stall;
  result_t              res_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DSQ_W-1:0]     cfg_data;

  logic [GRAV_W-1:0] grav_g;
  logic [DSQ_W-1:0]  dsq_lo;
  logic [DSQ_W-1:0]  dsq_hi;

  result_t force_q[$];
  int      errors;
  int      hold_cnt;
  bit      stall_on;

  pairwise_gravity_force u_top (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair_data(pair_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_pairwise_gravity_force NOT OK");
    $finish;
  end

  function automatic logic [31:0] force_axis(logic [63:0] mag, logic neg, logic [32:0] ad,
                                             logic [33:0] len, inout logic sat);
    logic [63:0]  u;
    logic [127:0] m;
    u = (64'(ad) << UNIT_BITS) / 64'(len);
    m = (128'(mag) * 128'(u)) >> UNIT_BITS;
    if (!neg) begin
      if (m > 128'h7FFF_FFFF) begin
        m = 128'h7FFF_FFFF;
        sat = 1'b1;
      end
      return m[31:0];
    end
    if (m > 128'h8000_0000) begin
      m = 128'h8000_0000;
      sat = 1'b1;
    end
    return -m[31:0];
  endfunction

  function automatic result_t calc_force(pair_t p);
    logic signed [33:0] dx, dy;
    logic [32:0]  ax, ay;
    logic [65:0]  s;
    logic [63:0]  v, c, mag;
    logic [127:0] prod, q;
    logic [33:0]  len, t;
    logic         sat;
    result_t      r;
    dx = {{2{p.b_pos_x[31]}}, p.b_pos_x} - {{2{p.a_pos_x[31]}}, p.a_pos_x};
    dy = {{2{p.b_pos_y[31]}}, p.b_pos_y} - {{2{p.a_pos_y[31]}}, p.a_pos_y};
    ax = dx[33] ? 33'(-dx) : 33'(dx);
    ay = dy[33] ? 33'(-dy) : 33'(dy);
    s = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    r = '0;
    if (s == 0) return r;
    v = (s[65:64] != 0) ? '1 : s[63:0];
    c = (v < dsq_lo) ? dsq_lo : (v > dsq_hi) ? dsq_hi : v;
    prod = 128'(grav_g) * 128'(p.a_mass) * 128'(p.b_mass);
    if (c == 0) begin
      mag = (prod == 0) ? 64'd0 : MAG_LIMIT;
    end else begin
      q = prod / 128'(c);
      mag = (q > 128'(MAG_LIMIT)) ? MAG_LIMIT : q[63:0];
    end
    len = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = len | (34'd1 << b);
      if (68'(t) * 68'(t) <= 68'(s)) len = t;
    end
    sat = 1'b0;
    r.force_x = force_axis(mag, dx[33], ax, len, sat);
    r.force_y = force_axis(mag, dy[33], ay, len, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: long hold first, then random stalls when enabled
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      res_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      res_stall <= stall_on && (pick_gap() != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (force_q.size() == 0) begin
        $display("%t: unexpected result %p", $realtime, res_data);
        errors++;
      end else begin
        result_t e;
        e = force_q.pop_front();
        if (res_data.force_x !== e.force_x) begin
          $display("%t: force_x expected %h actual %h", $realtime, e.force_x, res_data.force_x);
          errors++;
        end
        if (res_data.force_y !== e.force_y) begin
          $display("%t: force_y expected %h actual %h", $realtime, e.force_y, res_data.force_y);
          errors++;
        end
        if (res_data.saturated !== e.saturated) begin
          $display("%t: saturated expected %b actual %b", $realtime, e.saturated,
                   res_data.saturated);
          errors++;
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_pair(input pair_t p, input int gap);
    pair_data <= p;
    pair_valid <= 1'b1;
    do @(posedge clk); while (pair_stall);
    force_q.push_back(calc_force(p));
    @(negedge clk);
    if (gap > 0) begin
      pair_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    pair_valid <= 1'b0;
    while (force_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    drain();
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRAV:    grav_g = val[31:0];
      REG_MIN_DSQ: dsq_lo = val;
      REG_MAX_DSQ: dsq_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic pair_t mk_pair(int ax, int ay, int bx, int by, int unsigned ma,
                                    int unsigned mb);
    pair_t p;
    p.a_pos_x = ax; p.a_pos_y = ay; p.b_pos_x = bx; p.b_pos_y = by;
    p.a_mass = ma; p.b_mass = mb;
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.a_pos_x = $urandom; p.a_pos_y = $urandom;
    p.a_mass = $urandom; p.b_mass = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      // bodies close together, half the time with modest masses
      p.b_pos_x = p.a_pos_x + ($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
      p.b_pos_y = p.a_pos_y + ($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
      if ($urandom_range(0, 1)) begin
        p.a_mass = $urandom_range(0, 32'h0040_0000);
        p.b_mass = $urandom_range(0, 32'h0040_0000);
      end
    end else begin
      p.b_pos_x = $urandom;
      p.b_pos_y = $urandom;
    end
    if ($urandom_range(0, 40) == 0) begin
      p.b_pos_x = p.a_pos_x;
      p.b_pos_y = p.a_pos_y;
    end
    return p;
  endfunction

  task automatic test_corner_pairs();
    int unsigned one;
    one = 32'h0001_0000;
    send_pair(mk_pair(5, -7, 5, -7, one, one), 0);
    send_pair(mk_pair(0, 0, one, 0, one, one), 1);
    send_pair(mk_pair(0, 0, 0, -one, one, one), 0);
    send_pair(mk_pair(3 * one, 4 * one, 0, 0, 10 * one, 2 * one), 2);
    send_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_pair(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_pair(mk_pair(0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
    send_pair(mk_pair(0, 0, -1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 3);
    send_pair(mk_pair(0, 0, one, one, 0, 32'hFFFF_FFFF), 0);
    send_pair(mk_pair(0, 0, 20 * one, 0, one, one), 0);
    send_pair(mk_pair(0, 0, 0, 0, 0, 0), 0);
    write_reg(REG_MIN_DSQ, 64'd0);
    write_reg(REG_MAX_DSQ, 64'd0);
    send_pair(mk_pair(0, 0, one, 0, one, one), 0);
    send_pair(mk_pair(0, 0, 0, one, 0, one), 0);
    send_pair(mk_pair(0, 0, -one, one, 1, 1), 0);
    write_reg(REG_MIN_DSQ, 64'd50 << 32);
    write_reg(REG_MAX_DSQ, 64'd2 << 32);
    send_pair(mk_pair(0, 0, one, 0, one, one), 0);
    send_pair(mk_pair(0, 0, 10 * one, 0, one, one), 0);
    send_pair(mk_pair(0, 0, 0, -30 * one, one, one), 0);
    write_reg(REG_SPARE, 64'hDEAD_BEEF_0000_0001);
    send_pair(mk_pair(0, 0, 4 * one, -3 * one, one, one), 0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_GRAV, 32'h0001_0000);
    write_reg(REG_MIN_DSQ, MIN_DSQ_RESET);
    write_reg(REG_MAX_DSQ, MAX_DSQ_RESET);
    hold_cnt = 300;
    for (int i = 0; i < 150; i++) send_pair(rand_pair(), 0);
    drain();
  endtask

  task automatic run_phase(input logic [31:0] g, input logic [63:0] lo, input logic [63:0] hi,
                           input int n);
    write_reg(REG_GRAV, g);
    write_reg(REG_MIN_DSQ, lo);
    write_reg(REG_MAX_DSQ, hi);
    stall_on = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 39) stall_on = !stall_on;
      if ($urandom_range(0, 99) == 0) drain();
      send_pair(rand_pair(), (i % 80 < 40) ? pick_gap() : 0);
    end
    drain();
  endtask

  task automatic test_random_phases();
    run_phase(GRAV_RESET, MIN_DSQ_RESET, MAX_DSQ_RESET, 330);
    run_phase(32'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 150);
    run_phase(32'd0, 64'd1, 64'd1 << 40, 100);
    run_phase($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 150);
    run_phase($urandom, 64'd1 << 20, {$urandom_range(0, 255), $urandom}, 200);
    run_phase(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 100);
  endtask

  initial begin
    errors = 0;
    hold_cnt = 0;
    stall_on = 1'b0;
    rst = 1'b1;
    pair_valid = 1'b0;
    pair_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRAV;
    cfg_data = '0;
    res_stall = 1'b0;
    grav_g = GRAV_RESET;
    dsq_lo = MIN_DSQ_RESET;
    dsq_hi = MAX_DSQ_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_pairs();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0 && force_q.size() == 0) begin
      $display("tb_pairwise_gravity_force OK");
    end else begin
      $display("tb_pairwise_gravity_force NOT OK");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/pgf_pkg.sv
rtl/pgf_div.sv
rtl/pgf_sqrt.sv
rtl/pairwise_gravity_force.sv
rtl/pgf_checker.sv
tb/sv/tb_pairwise_gravity_force.sv
